// ----- design/chmt_pkg.sv -----
package chmt_pkg;

	localparam int OP_W   = 3;
	localparam int KEY_W  = 16;
	localparam int DATE_W = 32;
	localparam int CNT_W  = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int BUCKETS_DEF          = 10;
	localparam int SLOTS_PER_BUCKET_DEF = 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT     = 3'd0,
		OP_COUNT      = 3'd1,
		OP_QUERY      = 3'd2,
		OP_REMOVE_ONE = 3'd3,
		OP_REMOVE_ALL = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_HASH3,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic hash1;
		logic hash2;
		logic hash3;
		logic scan;
		logic commit;
		logic respond;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// ----- design/chmt_in_if.sv -----
interface chmt_in_if;
	logic                          valid;
	logic                          ready;
	logic [chmt_pkg::OP_W-1:0]     op;
	logic [chmt_pkg::KEY_W-1:0]    record_key;
	logic [chmt_pkg::DATE_W-1:0]   date_code;

	modport source(output valid, op, record_key, date_code, input ready);
	modport sink(input valid, op, record_key, date_code, output ready);
endinterface

// ----- design/chmt_out_if.sv -----
interface chmt_out_if;
	logic                          valid;
	logic                          ready;
	logic [chmt_pkg::CNT_W-1:0]    match_count;
	logic                          found;
	logic                          status;

	modport source(output valid, match_count, found, status, input ready);
	modport sink(input valid, match_count, found, status, output ready);
endinterface

// ----- design/chmt_ctrl.sv -----
module chmt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  chmt_pkg::sts_t  sts,
	output chmt_pkg::cmd_t  cmd
);

	chmt_pkg::state_t state_q;
	chmt_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			chmt_pkg::ST_IDLE: begin
				if (req_valid) state_next = chmt_pkg::ST_HASH1;
			end
			chmt_pkg::ST_HASH1:  state_next = chmt_pkg::ST_HASH2;
			chmt_pkg::ST_HASH2:  state_next = chmt_pkg::ST_HASH3;
			chmt_pkg::ST_HASH3:  state_next = chmt_pkg::ST_SCAN;
			chmt_pkg::ST_SCAN: begin
				if (sts.scan_last) state_next = chmt_pkg::ST_LAST;
			end
			chmt_pkg::ST_LAST:   state_next = chmt_pkg::ST_COMMIT;
			chmt_pkg::ST_COMMIT: state_next = chmt_pkg::ST_RESP;
			chmt_pkg::ST_RESP: begin
				if (sts.out_free) state_next = chmt_pkg::ST_IDLE;
			end
			default:             state_next = chmt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = (state_q == chmt_pkg::ST_IDLE);
		cmd         = '0;
		cmd.load    = (state_q == chmt_pkg::ST_IDLE) && req_valid;
		cmd.hash1   = (state_q == chmt_pkg::ST_HASH1);
		cmd.hash2   = (state_q == chmt_pkg::ST_HASH2);
		cmd.hash3   = (state_q == chmt_pkg::ST_HASH3);
		cmd.scan    = (state_q == chmt_pkg::ST_SCAN);
		cmd.commit  = (state_q == chmt_pkg::ST_COMMIT);
		cmd.respond = (state_q == chmt_pkg::ST_RESP) && sts.out_free;
	end

endmodule

// ----- design/chmt_datapath.sv -----
module chmt_datapath #(
	parameter int BUCKETS          = chmt_pkg::BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = chmt_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [chmt_pkg::OP_W-1:0]     op,
	input  logic [chmt_pkg::KEY_W-1:0]    record_key,
	input  logic [chmt_pkg::DATE_W-1:0]   date_code,
	input  chmt_pkg::cmd_t                cmd,
	output chmt_pkg::sts_t                sts,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [chmt_pkg::CNT_W-1:0]    match_count,
	output logic                          found,
	output logic                          status
);

	localparam int KW    = chmt_pkg::KEY_W;
	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int AW    = BW + SW;
	localparam int DEPTH = BUCKETS * (2 ** SW);
	localparam int RW    = BW + 1;
	localparam int PW    = 2 * KW + 1;
	localparam int QW    = KW + 8;

	// The quotient estimate from this reciprocal is the true quotient or one less,
	// so the remainder lands below twice the bucket count.
	localparam logic [KW:0]    RECIP     = (KW + 1)'((33'd1 << KW) / BUCKETS);
	localparam logic [RW-1:0]  BUCKETS_R = RW'(BUCKETS);
	localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOTS_PER_BUCKET - 1);

	logic [chmt_pkg::OP_W-1:0]    op_q;
	logic [KW-1:0]                key_q;
	logic [chmt_pkg::DATE_W-1:0]  date_q;

	logic [PW-1:0]  prod_s1;
	logic [RW-1:0]  rem_s2;
	logic [BW-1:0]  bucket_q;

	logic [SW-1:0]  slot_q;
	logic           chk_q;
	logic [SW-1:0]  rd_slot_q;
	logic           rd_valid_q;
	logic [KW-1:0]  rd_key_q;
	logic [chmt_pkg::DATE_W-1:0] rd_date_q;

	logic                        hit_q;
	logic [SW-1:0]               hit_slot_q;
	logic [chmt_pkg::CNT_W-1:0]  cnt_q;

	logic [DEPTH-1:0]             valid_q;
	logic [KW-1:0]                mem_key  [DEPTH];
	logic [chmt_pkg::DATE_W-1:0]  mem_date [DEPTH];

	logic                        out_valid_q;
	logic [chmt_pkg::CNT_W-1:0]  out_count_q;
	logic                        out_found_q;
	logic                        out_status_q;

	logic [KW-1:0]  q_est;
	logic [QW-1:0]  qb;
	logic [QW-1:0]  diff;
	logic [BW-1:0]  bucket_next;
	logic [AW-1:0]  scan_addr;
	logic [AW-1:0]  chk_addr;
	logic [AW-1:0]  hit_addr;
	logic           is_insert;
	logic           is_count;
	logic           is_query;
	logic           is_rem_one;
	logic           is_rem_all;
	logic           key_hit;
	logic           pair_hit;
	logic           first_free;

	assign q_est       = prod_s1[KW +: KW];
	assign qb          = QW'(q_est) * QW'(BUCKETS);
	assign diff        = QW'(key_q) - qb;
	assign bucket_next = (rem_s2 >= BUCKETS_R) ? BW'(rem_s2 - BUCKETS_R) : rem_s2[BW-1:0];

	assign scan_addr = {bucket_q, slot_q};
	assign chk_addr  = {bucket_q, rd_slot_q};
	assign hit_addr  = {bucket_q, hit_slot_q};

	assign is_insert  = (op_q == chmt_pkg::OP_INSERT);
	assign is_count   = (op_q == chmt_pkg::OP_COUNT);
	assign is_query   = (op_q == chmt_pkg::OP_QUERY);
	assign is_rem_one = (op_q == chmt_pkg::OP_REMOVE_ONE);
	assign is_rem_all = (op_q == chmt_pkg::OP_REMOVE_ALL);

	// Stored key and date only count while the slot's valid bit is set.
	assign key_hit    = chk_q && rd_valid_q && (rd_key_q == key_q);
	assign pair_hit   = key_hit && (rd_date_q == date_q) && !hit_q && (is_query || is_rem_one);
	assign first_free = chk_q && !rd_valid_q && !hit_q && is_insert;

	assign sts.scan_last = (slot_q == LAST_SLOT);
	assign sts.out_free  = !out_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			key_q  <= record_key;
			date_q <= date_code;
		end
		if (cmd.hash1) prod_s1 <= PW'(key_q) * PW'(RECIP);
		if (cmd.hash2) rem_s2 <= diff[RW-1:0];
		if (cmd.hash3) bucket_q <= bucket_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			chk_q      <= 1'b0;
			rd_slot_q  <= '0;
			rd_valid_q <= 1'b0;
			hit_q      <= 1'b0;
			hit_slot_q <= '0;
			cnt_q      <= '0;
		end else begin
			chk_q <= cmd.scan;
			if (cmd.load) begin
				slot_q <= '0;
				hit_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (cmd.scan) begin
				slot_q <= slot_q + SW'(1);
			end
			if (cmd.scan) begin
				rd_slot_q  <= slot_q;
				rd_valid_q <= valid_q[scan_addr];
			end
			if (first_free || pair_hit) begin
				hit_q      <= 1'b1;
				hit_slot_q <= rd_slot_q;
			end
			if (is_count && key_hit && (cnt_q != chmt_pkg::CNT_MAX)) begin
				cnt_q <= cnt_q + chmt_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			// The slot's valid bit was already sampled, so clearing it mid-scan is safe.
			if (is_rem_all && key_hit) valid_q[chk_addr] <= 1'b0;
			if (cmd.commit && hit_q) begin
				if (is_insert) begin
					valid_q[hit_addr] <= 1'b1;
				end else if (is_rem_one) begin
					valid_q[hit_addr] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && hit_q && is_insert) begin
			mem_key[hit_addr]  <= key_q;
			mem_date[hit_addr] <= date_q;
		end
		if (cmd.scan) begin
			rd_key_q  <= mem_key[scan_addr];
			rd_date_q <= mem_date[scan_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.respond) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			out_count_q  <= is_count ? cnt_q : '0;
			out_found_q  <= (is_query || is_rem_one) && hit_q;
			out_status_q <= is_insert && !hit_q;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign match_count = out_count_q;
	assign found       = out_found_q;
	assign status      = out_status_q;

endmodule

// ----- design/chained_hash_multiset_table_unit.sv -----
// Channel  Direction  Word
// req      in         op, record_key, date_code
// rsp      out        match_count, found, status
//
// One word on req passes from its acceptance to the earliest acceptance of the next word
// through three steps of bucket hashing, a bucket scan of one slot per cycle through the
// table's single read port, the last compare, the table update, loading the result, and
// the idle state in which req is ready again.
// The result sits in an output register, so a new word is taken while it waits;
// a stalled rsp holds the next result only at its final load.
// Reset clears every valid bit at once; no clearing pass is needed.
module chained_hash_multiset_table_unit #(
	parameter int BUCKETS          = chmt_pkg::BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = chmt_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	chmt_in_if.sink     req,
	chmt_out_if.source  rsp
);

	chmt_pkg::cmd_t cmd;
	chmt_pkg::sts_t sts;

	chmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	chmt_datapath #(
		.BUCKETS          (BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (req.op),
		.record_key  (req.record_key),
		.date_code   (req.date_code),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.match_count (rsp.match_count),
		.found       (rsp.found),
		.status      (rsp.status)
	);

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("new word taken while an operation is in flight");

	a_found_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.status))
		else $error("found and status both set in one result");

	a_count_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.match_count != '0)) |-> (!rsp.found && !rsp.status))
		else $error("nonzero count together with found or status");

endmodule

// ----- bench/tb_chained_hash_multiset_table_unit.sv -----
`timescale 1ns / 100ps

module tb_chained_hash_multiset_table_unit;
	import chmt_pkg::*;

	localparam int TABLE_DEPTH = BUCKETS_DEF * SLOTS_PER_BUCKET_DEF;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
	localparam int RANDOM_WORDS = 1000;
	localparam int POOL_REFRESH = 250;
	localparam int PHASE_WORDS  = 150;
	localparam int HOLD_AT_WORD = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  record_key;
		logic [DATE_W-1:0] date_code;
	} req_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] match_count;
		logic             found;
		logic             status;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n;

	chmt_in_if  req_ch ();
	chmt_out_if rsp_ch ();

	chained_hash_multiset_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the slot table.
	logic              shadow_valid [TABLE_DEPTH];
	logic [KEY_W-1:0]  shadow_key   [TABLE_DEPTH];
	logic [DATE_W-1:0] shadow_date  [TABLE_DEPTH];

	req_word_t req_backlog[$];
	rsp_word_t outstanding_rsp[$];
	req_word_t drive_word;
	rsp_word_t got_rsp;
	rsp_word_t want_rsp;
	int        accepted_cnt;
	int        error_count = 0;
	int        hold_left;
	bit        hold_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one word to the shadow table and returns the response it should produce.
	function automatic rsp_word_t table_apply(req_word_t w);
		int        base;
		int        hits;
		bit        done;
		rsp_word_t r;
		base = (w.record_key % BUCKETS_DEF) * SLOTS_PER_BUCKET_DEF;
		hits = 0;
		done = 1'b0;
		r    = '0;
		case (w.op)
			OP_INSERT: begin
				r.status = 1'b1;
				for (int s = 0; s < SLOTS_PER_BUCKET_DEF; s++) begin
					if (!done && !shadow_valid[base + s]) begin
						shadow_valid[base + s] = 1'b1;
						shadow_key[base + s]   = w.record_key;
						shadow_date[base + s]  = w.date_code;
						r.status = 1'b0;
						done = 1'b1;
					end
				end
			end
			OP_COUNT: begin
				for (int s = 0; s < SLOTS_PER_BUCKET_DEF; s++) begin
					if (shadow_valid[base + s] && shadow_key[base + s] == w.record_key)
						hits++;
				end
				r.match_count = (hits > int'(CNT_MAX)) ? CNT_MAX : hits[CNT_W-1:0];
			end
			OP_QUERY, OP_REMOVE_ONE: begin
				for (int s = 0; s < SLOTS_PER_BUCKET_DEF; s++) begin
					if (!done && shadow_valid[base + s] && shadow_key[base + s] == w.record_key
							&& shadow_date[base + s] == w.date_code) begin
						r.found = 1'b1;
						if (w.op == OP_REMOVE_ONE)
							shadow_valid[base + s] = 1'b0;
						done = 1'b1;
					end
				end
			end
			OP_REMOVE_ALL: begin
				for (int s = 0; s < SLOTS_PER_BUCKET_DEF; s++) begin
					if (shadow_valid[base + s] && shadow_key[base + s] == w.record_key)
						shadow_valid[base + s] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Idle percentage of either side for the phase the run is in.
	function automatic int idle_pct(bit receiver);
		case ((accepted_cnt / PHASE_WORDS) % 4)
			1:       return receiver ? 0 : 65;
			2:       return receiver ? 65 : 0;
			3:       return 24;
			default: return 0;
		endcase
	endfunction

	task automatic push_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [DATE_W-1:0] date);
		req_backlog.push_back(req_word_t'{op: op, record_key: key, date_code: date});
	endtask

	// Driver: a word stays on the bus until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.op         <= '0;
			req_ch.record_key <= '0;
			req_ch.date_code  <= '0;
			accepted_cnt      <= 0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				shadow_valid[i] = 1'b0;
				shadow_key[i]   = '0;
				shadow_date[i]  = '0;
			end
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				outstanding_rsp.push_back(table_apply({req_ch.op, req_ch.record_key,
					req_ch.date_code}));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
					drive_word = req_backlog.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.op         <= drive_word.op;
					req_ch.record_key <= drive_word.record_key;
					req_ch.date_code  <= drive_word.date_code;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off early in the run, so the block backs up into req.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_cnt >= HOLD_AT_WORD) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp = {rsp_ch.match_count, rsp_ch.found, rsp_ch.status};
				if (outstanding_rsp.size() == 0) begin
					error_count++;
					$display("%0t: unexpected rsp word: count=%0d found=%0b status=%0b",
						$realtime, got_rsp.match_count, got_rsp.found, got_rsp.status);
				end else begin
					want_rsp = outstanding_rsp.pop_front();
					if (got_rsp !== want_rsp) begin
						error_count++;
						$display("%0t: rsp mismatch: expected count=%0d found=%0b status=%0b, got count=%0d found=%0b status=%0b",
							$realtime, want_rsp.match_count, want_rsp.found, want_rsp.status,
							got_rsp.match_count, got_rsp.found, got_rsp.status);
					end
				end
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
		end
	end

	initial begin
		logic [KEY_W-1:0]  key_pool [6];
		logic [DATE_W-1:0] date_pool [3];
		int                bucket_a;
		int                bucket_b;
		int                pick;
		req_word_t         w;

		arst_n = 1'b0;

		// Directed part: empty table, duplicates, lowest-slot rules, a full bucket.
		push_word(OP_COUNT, '0, '0);
		push_word(OP_QUERY, '0, '0);
		push_word(OP_REMOVE_ONE, '0, '0);
		push_word(OP_REMOVE_ALL, '0, '1);
		push_word(OP_INSERT, '0, '0);
		push_word(OP_INSERT, '0, '1);
		push_word(OP_INSERT, '0, '0);
		push_word(OP_COUNT, '0, '1);
		push_word(OP_QUERY, '0, '1);
		push_word(OP_REMOVE_ONE, '0, '0);
		push_word(OP_INSERT, 16'd10, 32'd5);
		push_word(OP_COUNT, '0, '0);
		push_word(OP_INSERT, '1, 32'hAAAA_5555);
		for (int k = 0; k < SLOTS_PER_BUCKET_DEF - 1; k++)
			push_word(OP_INSERT, 16'(5 + 10 * k), 32'h5555_AAAA);
		push_word(OP_INSERT, '1, 32'h5555_AAAA);
		push_word(OP_QUERY, '1, 32'hAAAA_5555);
		push_word(OP_REMOVE_ALL, '0, '0);
		push_word(OP_SPARE_FIRST, '1, '1);
		push_word(OP_SPARE_LAST, '1, '1);

		// Random part: mostly small key and date pools over two buckets so that
		// inserts, hits and full buckets keep recurring; the rest is noise.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % POOL_REFRESH == 0) begin
				bucket_a = int'($urandom_range(0, BUCKETS_DEF - 1));
				bucket_b = int'($urandom_range(0, BUCKETS_DEF - 1));
				for (int i = 0; i < 6; i++)
					key_pool[i] = 16'(((i < 4) ? bucket_a : bucket_b) + 10 * $urandom_range(0, 6552));
				date_pool[0] = $urandom;
				date_pool[1] = $urandom;
				date_pool[2] = $urandom_range(0, 1) ? '0 : '1;
			end
			if ($urandom_range(0, 99) < 15) begin
				w.op         = OP_W'($urandom_range(0, 7));
				w.record_key = KEY_W'($urandom_range(0, 65535));
				w.date_code  = $urandom;
			end else begin
				pick = int'($urandom_range(0, 99));
				if (pick < 40)
					w.op = OP_INSERT;
				else if (pick < 55)
					w.op = OP_COUNT;
				else if (pick < 75)
					w.op = OP_QUERY;
				else if (pick < 90)
					w.op = OP_REMOVE_ONE;
				else if (pick < 95)
					w.op = OP_REMOVE_ALL;
				else
					w.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				w.record_key = key_pool[$urandom_range(0, 5)];
				w.date_code  = date_pool[$urandom_range(0, 2)];
			end
			req_backlog.push_back(w);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (outstanding_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
